[sv/tcht_pkg.sv]
// Shared constants, codes and types for the two-choice hash table engine.
`default_nettype none
package tcht_pkg;

	localparam int unsigned MAX_SLOTS   = 1024;
	localparam int unsigned IDX_W       = $clog2(MAX_SLOTS);
	localparam int unsigned ADDR_W      = IDX_W + 1;
	localparam int unsigned CNT_W       = IDX_W + 1;
	localparam int unsigned SIZE_W      = 11;
	localparam int unsigned NB_W        = SIZE_W + 1;
	localparam int unsigned START_SLOTS = 128;
	localparam int unsigned MIN_SLOTS   = 4;
	localparam int unsigned SHRINK_RATIO = 10;
	localparam int unsigned KEEP_RATIO   = 5;

	localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
	localparam int unsigned MIX_SHIFT = 33;
	localparam logic [63:0] SALT_SEED = 64'd1024;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_LOOKUP = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_REMOVED  = 3'd2,
		ST_FOUND    = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		GR_SHRINK = 2'd0,
		GR_KEEP   = 2'd1,
		GR_GROW   = 2'd2
	} grow_t;

	// Request to and response from the shared avalanche unit
	typedef struct packed {
		logic        start;
		logic [63:0] h;
		logic [63:0] salt;
	} mix_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res;
	} mix_rsp_t;

endpackage
`default_nettype wire

[sv/tcht_if.sv]
// Request and response channel interfaces of the hash table engine.
`default_nettype none
interface tcht_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [63:0] key;
	logic [63:0] data;

	modport source (output valid, mode, key, data, input ready);
	modport sink (input valid, mode, key, data, output ready);
endinterface

interface tcht_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] data_out;
	logic [10:0] table_slots;

	modport source (output valid, status, data_out, table_slots, input ready);
	modport sink (input valid, status, data_out, table_slots, output ready);
endinterface
`default_nettype wire

[sv/tcht_mix.sv]
// Salted fmix64 avalanche on one shared 32x32 multiplier, clamped to at least 2.
`default_nettype none
module tcht_mix (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tcht_pkg::mix_req_t req,
	output tcht_pkg::mix_rsp_t     rsp
);

	typedef enum logic [2:0] {
		MX_IDLE = 3'b001,
		MX_MUL  = 3'b010,
		MX_POST = 3'b100
	} mx_state_t;

	mx_state_t   state_q;
	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [1:0]  sub_q;
	logic        round_q;
	logic        done_q;

	logic [63:0] seed;
	logic [63:0] cst;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;
	logic [63:0] post;

	assign seed = req.h + req.salt;
	assign cst  = round_q ? tcht_pkg::MIX_C2 : tcht_pkg::MIX_C1;
	assign post = acc_q ^ (acc_q >> tcht_pkg::MIX_SHIFT);

	// Pick the partial product of this step
	always_comb begin
		case (sub_q)
			2'd0: begin
				op_a = x_q[31:0];
				op_b = cst[31:0];
			end
			2'd1: begin
				op_a = x_q[63:32];
				op_b = cst[31:0];
			end
			default: begin
				op_a = x_q[31:0];
				op_b = cst[63:32];
			end
		endcase
	end

	assign prod = 64'(op_a) * 64'(op_b);

	// Sequence add, xor-shift, two three-step multiplies each followed by xor-shift, then clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MX_IDLE;
			x_q     <= '0;
			acc_q   <= '0;
			sub_q   <= '0;
			round_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MX_IDLE: begin
					if (req.start) begin
						x_q     <= seed ^ (seed >> tcht_pkg::MIX_SHIFT);
						sub_q   <= 2'd0;
						round_q <= 1'b0;
						state_q <= MX_MUL;
					end
				end
				MX_MUL: begin
					if (sub_q == 2'd0) begin
						acc_q <= prod;
					end else begin
						acc_q <= acc_q + {prod[31:0], 32'd0};
					end
					if (sub_q == 2'd2) begin
						state_q <= MX_POST;
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
				MX_POST: begin
					sub_q <= 2'd0;
					if (!round_q) begin
						x_q     <= post;
						round_q <= 1'b1;
						state_q <= MX_MUL;
					end else begin
						x_q     <= (post < 64'd2) ? 64'd2 : post;
						done_q  <= 1'b1;
						state_q <= MX_IDLE;
					end
				end
				default: state_q <= MX_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = x_q;

endmodule
`default_nettype wire

[sv/two_choice_hash_table.sv]
// Top level of the two-choice hash table engine with rebuild on collision.
//
//  channel | dir | payload                                  | transaction
//  in_ch   | in  | mode[2], key[64], data[64]               | valid & ready
//  out_ch  | out | status[3], data_out[64], table_slots[11] | valid & ready
//
// Each hash runs on the shared multiplier unit. A lookup, remove or insert
// without rebuild shows its result after one hash and probe when the first
// candidate slot decides it, after a second hash and probe when it does not.
// Each rebuild attempt derives a new salt, clears the target bank, then walks
// the insertion list, skipping deleted entries and moving each live one.
// After reset the block clears all 2048 slots before taking work.
// One item at a time: in_ch.ready is high only while idle; a result waits in
// the output register until out_ch.ready, and the next transaction is taken in
// the cycle after it leaves at the earliest.
`default_nettype none
module two_choice_hash_table (
	input  wire logic clk,
	input  wire logic arst_n,
	tcht_req_if.sink   in_ch,
	tcht_rsp_if.source out_ch
);

	localparam int unsigned IW = tcht_pkg::IDX_W;
	localparam int unsigned AW = tcht_pkg::ADDR_W;
	localparam int unsigned CW = tcht_pkg::CNT_W;
	localparam int unsigned SW = tcht_pkg::SIZE_W;
	localparam int unsigned NW = tcht_pkg::NB_W;
	localparam int unsigned DEPTH = 2 * tcht_pkg::MAX_SLOTS;

	typedef enum logic [14:0] {
		S_CLR     = 15'b000000000000001,
		S_IDLE    = 15'b000000000000010,
		S_HASH    = 15'b000000000000100,
		S_PRB_RD  = 15'b000000000001000,
		S_PRB_CHK = 15'b000000000010000,
		S_PRB_MIX = 15'b000000000100000,
		S_RB_MIX  = 15'b000000001000000,
		S_RB_CLR  = 15'b000000010000000,
		S_RB_ORD  = 15'b000000100000000,
		S_RB_SRC  = 15'b000001000000000,
		S_RB_ENT  = 15'b000010000000000,
		S_RB_DRD  = 15'b000100000000000,
		S_RB_DCHK = 15'b001000000000000,
		S_RB_PMIX = 15'b010000000000000,
		S_RESP    = 15'b100000000000000
	} state_t;

	// Slot and order stores, both banks
	logic [63:0]   hash_mem [DEPTH];
	logic [63:0]   key_mem  [DEPTH];
	logic [63:0]   data_mem [DEPTH];
	logic [IW-1:0] ord_mem  [DEPTH];

	state_t                state_q;
	logic [1:0]            mode_q;
	logic [63:0]           key_q;
	logic [63:0]           data_q;
	logic [63:0]           h_q;
	logic [63:0]           cur_h_q;
	logic                  p_q;
	logic [IW-1:0]         pa_q;
	logic                  ab_q;
	logic                  bank_q;
	logic [SW-1:0]         size_q;
	logic [63:0]           salt_q;
	logic [CW-1:0]         len0_q;
	logic [CW-1:0]         len1_q;
	logic [SW-1:0]         live_q;
	logic [NW-1:0]         nb_q;
	logic [63:0]           salt_w_q;
	tcht_pkg::grow_t       grow_q;
	logic [AW-1:0]         clr_cnt_q;
	logic [CW-1:0]         j_q;
	logic [63:0]           ent_h_q;
	logic [63:0]           ent_k_q;
	logic [63:0]           ent_d_q;
	tcht_pkg::status_t     status_q;
	logic [63:0]           dout_q;

	logic [63:0]   hash_rd_q;
	logic [63:0]   key_rd_q;
	logic [63:0]   data_rd_q;
	logic [IW-1:0] ord_rd_q;

	tcht_pkg::mix_req_t mix_req;
	tcht_pkg::mix_rsp_t mix_rsp;

	logic          hw_en;
	logic          kd_en;
	logic [AW-1:0] hw_addr;
	logic [63:0]   hw_hash;
	logic [63:0]   hw_key;
	logic [63:0]   hw_data;
	logic [AW-1:0] rd_addr;
	logic          ow_en;
	logic [AW-1:0] ow_addr;
	logic [IW-1:0] ow_data;
	logic [AW-1:0] ord_rd_addr;

	logic [IW-1:0] size_mask;
	logic [IW-1:0] nb_mask;
	logic [IW-1:0] pidx;
	logic [IW-1:0] ridx;
	logic [CW-1:0] len_cur;
	logic [CW-1:0] len_dst;
	logic [IW-1:0] j_dec;
	logic          rd_empty;
	logic          rd_live;
	logic          rd_hit;
	logic          is_insert;
	logic [SW:0]   live_inc;
	logic [15:0]   shrink_lim;
	logic [15:0]   keep_lim;
	tcht_pkg::grow_t grow_first;
	tcht_pkg::grow_t grow_next;
	logic [NW-1:0] nb_half;
	logic [NW-1:0] nb_next;

	assign size_mask = size_q[IW-1:0] - IW'(1);
	assign nb_mask   = nb_q[IW-1:0] - IW'(1);
	assign pidx      = cur_h_q[IW-1:0] & size_mask;
	assign ridx      = cur_h_q[IW-1:0] & nb_mask;
	assign len_cur   = bank_q ? len1_q : len0_q;
	assign len_dst   = bank_q ? len0_q : len1_q;
	assign j_dec     = IW'(j_q - CW'(1));
	assign rd_empty  = (hash_rd_q == 64'd0);
	assign rd_live   = (hash_rd_q > 64'd1);
	assign rd_hit    = rd_live && (key_rd_q == key_q);
	assign is_insert = (mode_q == tcht_pkg::MODE_INSERT);

	// Sizing of the first rebuild: live < size/r  <=>  r*(live+1) <= size
	assign live_inc   = {1'b0, live_q} + (SW + 1)'(1);
	assign shrink_lim = 16'(live_inc) * 16'(tcht_pkg::SHRINK_RATIO);
	assign keep_lim   = 16'(live_inc) * 16'(tcht_pkg::KEEP_RATIO);

	always_comb begin
		if (ab_q) begin
			grow_first = tcht_pkg::GR_GROW;
		end else if (shrink_lim <= 16'(size_q)) begin
			grow_first = tcht_pkg::GR_SHRINK;
		end else if (keep_lim <= 16'(size_q)) begin
			grow_first = tcht_pkg::GR_KEEP;
		end else begin
			grow_first = tcht_pkg::GR_GROW;
		end
	end

	// Size of the next rebuild attempt
	assign nb_half = nb_q >> 1;
	always_comb begin
		case (grow_q)
			tcht_pkg::GR_SHRINK: begin
				nb_next   = (nb_half < NW'(tcht_pkg::MIN_SLOTS)) ?
				            NW'(tcht_pkg::MIN_SLOTS) : nb_half;
				grow_next = tcht_pkg::GR_KEEP;
			end
			tcht_pkg::GR_KEEP: begin
				nb_next   = nb_q;
				grow_next = tcht_pkg::GR_GROW;
			end
			default: begin
				nb_next   = nb_q << 1;
				grow_next = tcht_pkg::GR_GROW;
			end
		endcase
	end

	// Memory ports and avalanche requests
	always_comb begin
		hw_en       = 1'b0;
		kd_en       = 1'b0;
		hw_addr     = '0;
		hw_hash     = '0;
		hw_key      = key_q;
		hw_data     = data_q;
		rd_addr     = '0;
		ow_en       = 1'b0;
		ow_addr     = '0;
		ow_data     = pa_q;
		ord_rd_addr = '0;
		mix_req     = '0;
		case (state_q)
			S_CLR: begin
				hw_en         = 1'b1;
				hw_addr       = clr_cnt_q;
				mix_req.start = (clr_cnt_q == '0);
				mix_req.h     = tcht_pkg::SALT_SEED;
			end
			S_IDLE: begin
				mix_req.start = in_ch.valid;
				mix_req.h     = in_ch.key;
			end
			S_PRB_RD: begin
				rd_addr = {bank_q, pidx};
			end
			S_PRB_CHK: begin
				if (is_insert) begin
					if (rd_empty) begin
						hw_en   = 1'b1;
						kd_en   = 1'b1;
						hw_addr = {bank_q, pa_q};
						hw_hash = h_q;
						ow_en   = (len_cur < CW'(tcht_pkg::MAX_SLOTS));
						ow_addr = {bank_q, len_cur[IW-1:0]};
					end else if (!rd_hit && !p_q) begin
						mix_req.start = 1'b1;
						mix_req.h     = cur_h_q;
						mix_req.salt  = salt_q;
					end else if (!rd_hit) begin
						mix_req.start = 1'b1;
						mix_req.h     = salt_q;
					end
				end else begin
					if (rd_hit && mode_q == tcht_pkg::MODE_REMOVE) begin
						hw_en   = 1'b1;
						hw_addr = {bank_q, pa_q};
						hw_hash = 64'd1;
					end else if (!rd_hit && !p_q) begin
						mix_req.start = 1'b1;
						mix_req.h     = cur_h_q;
						mix_req.salt  = salt_q;
					end
				end
			end
			S_RB_CLR: begin
				hw_en   = 1'b1;
				hw_addr = {~bank_q, clr_cnt_q[IW-1:0]};
			end
			S_RB_ORD: begin
				ord_rd_addr = {bank_q, j_dec};
			end
			S_RB_SRC: begin
				rd_addr = {bank_q, ord_rd_q};
			end
			S_RB_DRD: begin
				rd_addr = {~bank_q, ridx};
			end
			S_RB_DCHK: begin
				if (rd_empty) begin
					hw_en   = 1'b1;
					kd_en   = 1'b1;
					hw_addr = {~bank_q, pa_q};
					hw_hash = ent_h_q;
					hw_key  = ent_k_q;
					hw_data = ent_d_q;
					ow_en   = (len_dst < CW'(tcht_pkg::MAX_SLOTS));
					ow_addr = {~bank_q, len_dst[IW-1:0]};
				end else if (!p_q) begin
					mix_req.start = 1'b1;
					mix_req.h     = cur_h_q;
					mix_req.salt  = salt_w_q;
				end else begin
					mix_req.start = 1'b1;
					mix_req.h     = salt_w_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Slot stores: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (hw_en) begin
			hash_mem[hw_addr] <= hw_hash;
		end
		hash_rd_q <= hash_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (kd_en) begin
			key_mem[hw_addr]  <= hw_key;
			data_mem[hw_addr] <= hw_data;
		end
		key_rd_q  <= key_mem[rd_addr];
		data_rd_q <= data_mem[rd_addr];
	end

	// Insertion list store
	always_ff @(posedge clk) begin
		if (ow_en) begin
			ord_mem[ow_addr] <= ow_data;
		end
		ord_rd_q <= ord_mem[ord_rd_addr];
	end

	tcht_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mix_req),
		.rsp    (mix_rsp)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			mode_q    <= '0;
			key_q     <= '0;
			data_q    <= '0;
			h_q       <= '0;
			cur_h_q   <= '0;
			p_q       <= 1'b0;
			pa_q      <= '0;
			ab_q      <= 1'b0;
			bank_q    <= 1'b0;
			size_q    <= SW'(tcht_pkg::START_SLOTS);
			salt_q    <= '0;
			len0_q    <= '0;
			len1_q    <= '0;
			live_q    <= '0;
			nb_q      <= '0;
			salt_w_q  <= '0;
			grow_q    <= tcht_pkg::GR_GROW;
			clr_cnt_q <= '0;
			j_q       <= '0;
			ent_h_q   <= '0;
			ent_k_q   <= '0;
			ent_d_q   <= '0;
			status_q  <= tcht_pkg::ST_INSERTED;
			dout_q    <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (mix_rsp.done) begin
						salt_q <= mix_rsp.res;
					end
					if (clr_cnt_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_ch.valid) begin
						mode_q  <= in_ch.mode;
						key_q   <= in_ch.key;
						data_q  <= in_ch.data;
						ab_q    <= 1'b0;
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (mix_rsp.done) begin
						h_q     <= mix_rsp.res;
						cur_h_q <= mix_rsp.res;
						p_q     <= 1'b0;
						state_q <= S_PRB_RD;
					end
				end
				S_PRB_RD: begin
					pa_q    <= pidx;
					state_q <= S_PRB_CHK;
				end
				S_PRB_CHK: begin
					if (is_insert) begin
						dout_q <= '0;
						if (rd_empty) begin
							if (len_cur < CW'(tcht_pkg::MAX_SLOTS)) begin
								if (bank_q) begin
									len1_q <= len1_q + CW'(1);
								end else begin
									len0_q <= len0_q + CW'(1);
								end
							end
							if (live_q < SW'(tcht_pkg::MAX_SLOTS)) begin
								live_q <= live_q + SW'(1);
							end
							status_q <= tcht_pkg::ST_INSERTED;
							state_q  <= S_RESP;
						end else if (rd_hit) begin
							status_q <= tcht_pkg::ST_PRESENT;
							state_q  <= S_RESP;
						end else if (!p_q) begin
							state_q <= S_PRB_MIX;
						end else begin
							grow_q   <= grow_first;
							nb_q     <= {1'b0, size_q};
							salt_w_q <= salt_q;
							state_q  <= S_RB_MIX;
						end
					end else begin
						if (rd_hit) begin
							dout_q <= data_rd_q;
							if (mode_q == tcht_pkg::MODE_REMOVE) begin
								if (live_q != '0) begin
									live_q <= live_q - SW'(1);
								end
								status_q <= tcht_pkg::ST_REMOVED;
							end else begin
								status_q <= tcht_pkg::ST_FOUND;
							end
							state_q <= S_RESP;
						end else if (!p_q) begin
							state_q <= S_PRB_MIX;
						end else begin
							dout_q   <= '0;
							status_q <= tcht_pkg::ST_NOTFOUND;
							state_q  <= S_RESP;
						end
					end
				end
				S_PRB_MIX: begin
					if (mix_rsp.done) begin
						cur_h_q <= mix_rsp.res;
						p_q     <= 1'b1;
						state_q <= S_PRB_RD;
					end
				end
				S_RB_MIX: begin
					if (mix_rsp.done) begin
						salt_w_q <= mix_rsp.res;
						grow_q   <= grow_next;
						if (nb_next > NW'(tcht_pkg::MAX_SLOTS)) begin
							status_q <= tcht_pkg::ST_FULL;
							dout_q   <= '0;
							state_q  <= S_RESP;
						end else begin
							nb_q      <= nb_next;
							clr_cnt_q <= '0;
							state_q   <= S_RB_CLR;
						end
					end
				end
				S_RB_CLR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q[IW-1:0] == '1) begin
						if (bank_q) begin
							len0_q <= '0;
						end else begin
							len1_q <= '0;
						end
						j_q     <= len_cur;
						state_q <= S_RB_ORD;
					end
				end
				S_RB_ORD: begin
					if (j_q == '0) begin
						bank_q  <= ~bank_q;
						size_q  <= nb_q[SW-1:0];
						salt_q  <= salt_w_q;
						ab_q    <= 1'b1;
						cur_h_q <= h_q;
						p_q     <= 1'b0;
						state_q <= S_PRB_RD;
					end else begin
						j_q     <= j_q - CW'(1);
						state_q <= S_RB_SRC;
					end
				end
				S_RB_SRC: begin
					state_q <= S_RB_ENT;
				end
				S_RB_ENT: begin
					ent_h_q <= hash_rd_q;
					ent_k_q <= key_rd_q;
					ent_d_q <= data_rd_q;
					if (rd_live) begin
						cur_h_q <= hash_rd_q;
						p_q     <= 1'b0;
						state_q <= S_RB_DRD;
					end else begin
						state_q <= S_RB_ORD;
					end
				end
				S_RB_DRD: begin
					pa_q    <= ridx;
					state_q <= S_RB_DCHK;
				end
				S_RB_DCHK: begin
					if (rd_empty) begin
						if (len_dst < CW'(tcht_pkg::MAX_SLOTS)) begin
							if (bank_q) begin
								len0_q <= len0_q + CW'(1);
							end else begin
								len1_q <= len1_q + CW'(1);
							end
						end
						state_q <= S_RB_ORD;
					end else if (!p_q) begin
						state_q <= S_RB_PMIX;
					end else begin
						state_q <= S_RB_MIX;
					end
				end
				// Wait for the second candidate of the entry being moved
				S_RB_PMIX: begin
					if (mix_rsp.done) begin
						cur_h_q <= mix_rsp.res;
						p_q     <= 1'b1;
						state_q <= S_RB_DRD;
					end
				end
				S_RESP: begin
					if (out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ch.ready        = (state_q == S_IDLE);
	assign out_ch.valid       = (state_q == S_RESP);
	assign out_ch.status      = status_q;
	assign out_ch.data_out    = dout_q;
	assign out_ch.table_slots = size_q;

endmodule
`default_nettype wire
